[src/pva_pkg.sv]
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types, field widths and cell command codes for the voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int NUM_VOICES_DEF = 8;

    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int VOICE_W = 3;

    typedef logic [NOTE_W-1:0]  t_note;
    typedef logic [VEL_W-1:0]   t_vel;
    typedef logic [VOICE_W-1:0] t_voice;

    // message and event codes
    localparam logic ACTION_NOTE_OFF = 1'b0;
    localparam logic ACTION_NOTE_ON  = 1'b1;
    localparam logic EVT_RELEASE     = 1'b0;
    localparam logic EVT_START       = 1'b1;

    typedef struct packed {
        logic  action;
        t_note note;
        t_vel  velocity;
    } t_in_item;

    typedef struct packed {
        logic   event_kind;
        t_voice voice_index;
        t_note  note_out;
        t_vel   velocity_out;
        logic   stolen;
    } t_out_item;

    // free list operations (cell 0 holds the back of the list)
    typedef logic [1:0] t_free_op;
    localparam t_free_op FREE_HOLD = 2'd0;
    localparam t_free_op FREE_POP  = 2'd1;
    localparam t_free_op FREE_PUSH = 2'd2;

    // active list operations (cell 0 holds the newest entry)
    typedef logic [1:0] t_act_op;
    localparam t_act_op ACT_HOLD = 2'd0;
    localparam t_act_op ACT_INS  = 2'd1;
    localparam t_act_op ACT_DEL  = 2'd2;

    typedef struct packed {
        t_free_op free_op;
        t_act_op  act_op;
        logic     srch_clr;
    } t_cell_cmd;

endpackage

[src/poly_voice_allocator_top.sv]
// ----------------------------------------------------------------------------
// poly_voice_allocator_top
// Polyphonic voice allocator with oldest-note stealing, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one note
//   message a beat: action, note, velocity. Output channel (o_out_valid /
//   i_out_stall / o_out_item) carries at most one voice event per message.
//   A note on takes the back of the free list, or steals the oldest active
//   voice when none is free. A note off (or note on at velocity zero) frees
//   the newest active voice playing that note; an unmatched release gives
//   no beat.
// Timing:
//   One message at a time. A note on goes from accept straight to the commit
//   state. A release passes through the search state first: the search token
//   walks the cell row one cell per cycle before the commit.
//   The result shows on o_out_valid the cycle after commit.
// Reset:
//   Synchronous, active low. Free list holds voices 0..NUM_VOICES-1, active
//   list is empty, output register is empty. No clearing pass is needed.
// Back-pressure:
//   The output register holds its beat while i_out_stall is high; a new
//   message may be accepted meanwhile, but its commit waits for the register.
// ----------------------------------------------------------------------------
module poly_voice_allocator_top #(
    parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pva_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pva_pkg::t_out_item  o_out_item
);
    import pva_pkg::*;

    localparam int VID_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W = $clog2(NUM_VOICES + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SRCH   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [VID_W-1:0] r_step,  n_step;
    logic [CNT_W-1:0] r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0] r_act_cnt,  n_act_cnt;
    t_in_item         r_in;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    // cell row taps
    logic [VID_W-1:0] w_free      [NUM_VOICES];
    logic [VID_W-1:0] w_act_voice [NUM_VOICES];
    t_note            w_act_note  [NUM_VOICES];
    logic             w_seen      [NUM_VOICES];
    logic [VID_W-1:0] w_vid       [NUM_VOICES];

    t_cell_cmd        w_cmd;
    logic             w_accept;
    logic             w_is_on;
    logic             w_steal;
    logic             w_found;
    logic             w_slot_free;
    logic             w_commit;
    logic [VID_W-1:0] w_on_voice;
    logic [VID_W-1:0] w_found_vid;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_is_on     = (r_in.action == ACTION_NOTE_ON) && (r_in.velocity != '0);
    assign w_steal     = (r_free_cnt == '0);
    // when nothing is free every voice is active, so the oldest is the last cell
    assign w_on_voice  = w_steal ? w_act_voice[NUM_VOICES-1] : w_free[0];
    assign w_found     = w_seen[NUM_VOICES-1];
    assign w_found_vid = w_vid[NUM_VOICES-1];
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_commit    = (r_state == S_COMMIT) && w_slot_free;

    // ---- cell commands ----
    always_comb begin
        w_cmd          = '0;
        w_cmd.free_op  = FREE_HOLD;
        w_cmd.act_op   = ACT_HOLD;
        w_cmd.srch_clr = w_accept;
        if (w_commit) begin
            if (w_is_on) begin
                w_cmd.act_op  = ACT_INS;
                w_cmd.free_op = w_steal ? FREE_HOLD : FREE_POP;
            end else if (w_found) begin
                w_cmd.act_op  = ACT_DEL;
                w_cmd.free_op = FREE_PUSH;
            end
        end
    end

    // ---- cell row ----
    for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
        logic [VID_W-1:0] w_pv;
        t_note            w_pn;
        logic [VID_W-1:0] w_nv;
        t_note            w_nn;
        logic [VID_W-1:0] w_nf;
        logic             w_ps;
        logic [VID_W-1:0] w_pid;

        if (g == 0) begin : g_head
            assign w_pv  = w_on_voice;
            assign w_pn  = r_in.note;
            assign w_ps  = 1'b0;
            assign w_pid = '0;
        end else begin : g_body
            assign w_pv  = w_act_voice[g-1];
            assign w_pn  = w_act_note[g-1];
            assign w_ps  = w_seen[g-1];
            assign w_pid = w_vid[g-1];
        end

        if (g == NUM_VOICES - 1) begin : g_tail
            assign w_nv = '0;
            assign w_nn = '0;
            assign w_nf = '0;
        end else begin : g_link
            assign w_nv = w_act_voice[g+1];
            assign w_nn = w_act_note[g+1];
            assign w_nf = w_free[g+1];
        end

        pva_cell #(
            .NUM_VOICES (NUM_VOICES),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_free_cnt   (r_free_cnt),
            .i_act_cnt    (r_act_cnt),
            .i_push_voice (w_found_vid),
            .i_key_note   (r_in.note),
            .i_prev_voice (w_pv),
            .i_prev_note  (w_pn),
            .i_next_voice (w_nv),
            .i_next_note  (w_nn),
            .i_next_free  (w_nf),
            .i_prev_seen  (w_ps),
            .i_prev_vid   (w_pid),
            .o_free       (w_free[g]),
            .o_act_voice  (w_act_voice[g]),
            .o_act_note   (w_act_note[g]),
            .o_seen       (w_seen[g]),
            .o_vid        (w_vid[g])
        );
    end

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_free_cnt  = r_free_cnt;
        n_act_cnt   = r_act_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_step = '0;
                    // a note on needs no search
                    if ((i_in_item.action == ACTION_NOTE_ON) && (i_in_item.velocity != '0)) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                // stay here until the token has walked to the end of the row
                if (r_step == VID_W'(NUM_VOICES - 1)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_COMMIT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                    if (w_is_on) begin
                        n_out.event_kind   = EVT_START;
                        n_out.voice_index  = VOICE_W'(w_on_voice);
                        n_out.stolen       = w_steal;
                        n_out_valid        = 1'b1;
                        if (!w_steal) begin
                            n_free_cnt = r_free_cnt - 1'b1;
                            n_act_cnt  = r_act_cnt + 1'b1;
                        end
                    end else if (w_found) begin
                        n_out.event_kind   = EVT_RELEASE;
                        n_out.voice_index  = VOICE_W'(w_found_vid);
                        n_out.stolen       = 1'b0;
                        n_out_valid        = 1'b1;
                        n_free_cnt         = r_free_cnt + 1'b1;
                        n_act_cnt          = r_act_cnt - 1'b1;
                    end
                    n_out.note_out     = r_in.note;
                    n_out.velocity_out = r_in.velocity;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_free_cnt  <= CNT_W'(NUM_VOICES);
            r_act_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_free_cnt  <= n_free_cnt;
            r_act_cnt   <= n_act_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    // every voice sits on exactly one of the two lists
    a_voice_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_free_cnt} + {1'b0, r_act_cnt}) == (CNT_W + 1)'(NUM_VOICES))
        else $error("voice lists lost or duplicated a voice");

    // a steal only happens with the free list empty, and leaves it empty
    a_steal_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.stolen) |-> (r_free_cnt == '0))
        else $error("steal reported while a voice was free");

    // a release never reports a steal
    a_release_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.event_kind == EVT_RELEASE)) |-> !o_out_item.stolen)
        else $error("release flagged as steal");

    // an accepted message always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted message not processed");
`endif

endmodule

[src/pva_cell.sv]
// ----------------------------------------------------------------------------
// pva_cell
// One slot of the allocator: a free list entry, an active list entry and the
// search token that ripples down the row one cell per cycle.
// ----------------------------------------------------------------------------
module pva_cell #(
    parameter int  NUM_VOICES = pva_pkg::NUM_VOICES_DEF,
    parameter int  IDX        = 0,
    localparam int VID_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
    localparam int CNT_W      = $clog2(NUM_VOICES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pva_pkg::t_cell_cmd    i_cmd,
    input  logic [CNT_W-1:0]      i_free_cnt,
    input  logic [CNT_W-1:0]      i_act_cnt,
    input  logic [VID_W-1:0]      i_push_voice,
    input  pva_pkg::t_note        i_key_note,
    input  logic [VID_W-1:0]      i_prev_voice,
    input  pva_pkg::t_note        i_prev_note,
    input  logic [VID_W-1:0]      i_next_voice,
    input  pva_pkg::t_note        i_next_note,
    input  logic [VID_W-1:0]      i_next_free,
    input  logic                  i_prev_seen,
    input  logic [VID_W-1:0]      i_prev_vid,
    output logic [VID_W-1:0]      o_free,
    output logic [VID_W-1:0]      o_act_voice,
    output pva_pkg::t_note        o_act_note,
    output logic                  o_seen,
    output logic [VID_W-1:0]      o_vid
);
    import pva_pkg::*;

    logic [VID_W-1:0] r_free;
    logic [VID_W-1:0] r_act_voice;
    t_note            r_act_note;
    logic             r_seen;      // a match exists in some cell above
    logic [VID_W-1:0] r_vid;       // voice of the first match above

    logic w_match;
    logic w_push_here;

    assign w_match     = (r_act_note == i_key_note) && (CNT_W'(IDX) < i_act_cnt);
    assign w_push_here = (CNT_W'(IDX) == i_free_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= VID_W'(NUM_VOICES - 1 - IDX);
            r_seen <= 1'b0;
        end else begin
            case (i_cmd.free_op)
                FREE_POP:  r_free <= i_next_free;
                FREE_PUSH: r_free <= w_push_here ? i_push_voice : r_free;
                default:   r_free <= r_free;
            endcase
            r_seen <= i_cmd.srch_clr ? 1'b0 : i_prev_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.act_op)
            ACT_INS: begin
                r_act_voice <= i_prev_voice;
                r_act_note  <= i_prev_note;
            end
            ACT_DEL: begin
                // cells at or below the released entry close the gap
                if (o_seen) begin
                    r_act_voice <= i_next_voice;
                    r_act_note  <= i_next_note;
                end
            end
            default: begin
                r_act_voice <= r_act_voice;
                r_act_note  <= r_act_note;
            end
        endcase
        r_vid <= i_prev_vid;
    end

    assign o_free      = r_free;
    assign o_act_voice = r_act_voice;
    assign o_act_note  = r_act_note;
    assign o_seen      = r_seen | w_match;
    assign o_vid       = r_seen ? r_vid : r_act_voice;

endmodule

[bench/poly_voice_allocator_top_test.sv]
// ----------------------------------------------------------------------------
// poly_voice_allocator_top_test
// Self-checking bench for the voice allocator: note messages are streamed in,
// a local model of the free and active lists predicts every voice event, and
// each output beat is checked against the oldest predicted event.
// ----------------------------------------------------------------------------
module poly_voice_allocator_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pva_pkg::*;

    localparam int NUM_VOICES   = NUM_VOICES_DEF;
    localparam int RANDOM_MSGS  = 1030;
    localparam int SEGMENT_LEN  = 40;      // note pool and on/off mix change per segment
    localparam int SETTLE_CYCLES = 4 * (NUM_VOICES + 4);
    localparam int CYCLE_LIMIT  = 250000;

    typedef struct {
        t_in_item msg;
        bit       drain;   // hold this message back until no event is outstanding
    } t_pending_msg;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    t_pending_msg msg_queue[$];
    t_out_item    voice_events[$];   // predicted events not yet seen on the output
    int           total_msgs;
    int           accepted_msgs;
    int           error_cnt;
    int           cycle_cnt;

    // local copy of the allocator state
    t_voice free_voices [NUM_VOICES];
    int     free_cnt;
    t_voice act_voice [NUM_VOICES];
    t_note  act_note  [NUM_VOICES];
    int     act_cnt;

    poly_voice_allocator_top #(
        .NUM_VOICES (NUM_VOICES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Applies one accepted message to the local lists. Returns 1 with the
    // expected event when the message produces a beat.
    function automatic bit allocate_voice(input t_in_item m, output t_out_item ev);
        t_voice v;
        bit     steal;
        ev = '0;
        if (m.action == ACTION_NOTE_ON && m.velocity != '0) begin
            if (free_cnt > 0) begin
                free_cnt--;
                v     = free_voices[free_cnt];
                steal = 1'b0;
            end else begin
                // nothing free: take the oldest active voice
                act_cnt--;
                v     = act_voice[act_cnt];
                steal = 1'b1;
            end
            for (int i = act_cnt; i > 0; i--) begin
                act_voice[i] = act_voice[i-1];
                act_note[i]  = act_note[i-1];
            end
            act_voice[0] = v;
            act_note[0]  = m.note;
            act_cnt++;
            ev.event_kind   = EVT_START;
            ev.voice_index  = v;
            ev.note_out     = m.note;
            ev.velocity_out = m.velocity;
            ev.stolen       = steal;
            return 1'b1;
        end
        // release: newest matching entry wins
        for (int i = 0; i < act_cnt; i++) begin
            if (act_note[i] == m.note) begin
                v = act_voice[i];
                for (int j = i; j + 1 < act_cnt; j++) begin
                    act_voice[j] = act_voice[j+1];
                    act_note[j]  = act_note[j+1];
                end
                act_cnt--;
                for (int j = free_cnt; j > 0; j--) begin
                    free_voices[j] = free_voices[j-1];
                end
                free_voices[0] = v;
                free_cnt++;
                ev.event_kind   = EVT_RELEASE;
                ev.voice_index  = v;
                ev.note_out     = m.note;
                ev.velocity_out = m.velocity;
                ev.stolen       = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Idle rates per third of the run: sender 28 / receiver 55, then swapped,
    // then flat out.
    function automatic int send_idle_pct();
        if (accepted_msgs < total_msgs / 3) return 28;
        if (accepted_msgs < 2 * total_msgs / 3) return 55;
        return 0;
    endfunction

    function automatic int recv_stall_pct();
        if (accepted_msgs < total_msgs / 3) return 55;
        if (accepted_msgs < 2 * total_msgs / 3) return 28;
        return 0;
    endfunction

    function automatic void add_msg(input logic act, input int note, input int vel,
                                    input bit drain);
        t_pending_msg p;
        p.msg.action   = act;
        p.msg.note     = t_note'(note);
        p.msg.velocity = t_vel'(vel);
        p.drain        = drain;
        msg_queue.insert(msg_queue.size(), p);
    endfunction

    function automatic string event_text(input t_out_item e);
        return $sformatf("kind=%0d voice=%0d note=%0d vel=%0d stolen=%0d",
                         e.event_kind, e.voice_index, e.note_out,
                         e.velocity_out, e.stolen);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: the predictor is updated on every accepted beat; valid is only
    // dropped or refilled once the current beat has gone.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_msgs
        bit           taken;
        bit           present;
        t_out_item    ev;
        t_in_item     nxt;
        t_pending_msg head;
        if (i_rst_n) begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                accepted_msgs++;
                if (allocate_voice(i_in_item, ev)) begin
                    voice_events.insert(voice_events.size(), ev);
                end
            end
            if (!i_in_valid || taken) begin
                present = 1'b0;
                nxt     = i_in_item;
                if (msg_queue.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
                    // a drain message waits for every outstanding event first
                    if (!msg_queue[0].drain || voice_events.size() == 0) begin
                        head    = msg_queue.pop_front();
                        nxt     = head.msg;
                        present = 1'b1;
                    end
                end
                i_in_valid <= present;
                i_in_item  <= nxt;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each output beat with the oldest predicted event, and
    // apply random back-pressure.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_events
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (voice_events.size() == 0) begin
                    error_cnt++;
                    $display("%0t: unexpected event, expected none, actual %s",
                             $time, event_text(o_out_item));
                end else begin
                    want = voice_events.pop_front();
                    if (o_out_item !== want) begin
                        error_cnt++;
                        $display("%0t: event differs, expected %s, actual %s",
                                 $time, event_text(want), event_text(o_out_item));
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct());
        end
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("poly_voice_allocator_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int base;
        int on_pct;
        int roll;
        for (int i = 0; i < NUM_VOICES; i++) begin
            free_voices[i] = t_voice'(i);
            act_voice[i]   = '0;
            act_note[i]    = '0;
        end
        free_cnt      = NUM_VOICES;
        act_cnt       = 0;
        accepted_msgs = 0;
        error_cnt     = 0;

        // directed: field extremes, fill-up, stealing, duplicate notes,
        // unmatched releases and velocity-zero note on
        add_msg(ACTION_NOTE_ON,  0,   127, 1'b0);
        add_msg(ACTION_NOTE_ON,  127, 1,   1'b0);
        add_msg(ACTION_NOTE_ON,  60,  64,  1'b0);
        add_msg(ACTION_NOTE_ON,  60,  100, 1'b0);   // same note held twice
        add_msg(ACTION_NOTE_ON,  61,  2,   1'b0);
        add_msg(ACTION_NOTE_ON,  62,  85,  1'b0);
        add_msg(ACTION_NOTE_ON,  63,  42,  1'b0);
        add_msg(ACTION_NOTE_ON,  64,  126, 1'b0);   // every voice busy now
        add_msg(ACTION_NOTE_ON,  65,  127, 1'b0);   // steals the oldest
        add_msg(ACTION_NOTE_ON,  66,  33,  1'b0);   // steals again
        add_msg(ACTION_NOTE_OFF, 60,  0,   1'b0);   // newest of the two
        add_msg(ACTION_NOTE_OFF, 60,  127, 1'b0);   // then the older one
        add_msg(ACTION_NOTE_OFF, 99,  50,  1'b0);   // no match
        add_msg(ACTION_NOTE_ON,  61,  0,   1'b0);   // velocity zero releases
        add_msg(ACTION_NOTE_OFF, 0,   10,  1'b0);   // stolen earlier, no match
        add_msg(ACTION_NOTE_ON,  1,   127, 1'b0);
        add_msg(ACTION_NOTE_OFF, 62,  1,   1'b0);
        add_msg(ACTION_NOTE_OFF, 63,  64,  1'b0);
        add_msg(ACTION_NOTE_OFF, 64,  127, 1'b0);
        add_msg(ACTION_NOTE_OFF, 65,  0,   1'b0);
        add_msg(ACTION_NOTE_OFF, 66,  77,  1'b0);
        add_msg(ACTION_NOTE_OFF, 1,   127, 1'b0);   // list empty again
        add_msg(ACTION_NOTE_OFF, 1,   3,   1'b0);   // release on an empty list
        add_msg(ACTION_NOTE_ON,  5,   0,   1'b0);   // zero-velocity on, no match

        // random: notes from a narrow pool so releases mostly hit, with the
        // on/off balance shifting so the lists swing between full and empty
        base   = 0;
        on_pct = 50;
        for (int n = 0; n < RANDOM_MSGS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                base   = $urandom_range(122);
                on_pct = $urandom_range(70, 35);
            end
            roll = $urandom_range(99);
            if (roll < on_pct) begin
                add_msg(ACTION_NOTE_ON, base + $urandom_range(5),
                        $urandom_range(127, 1), n == 350 || n == 700);
            end else if (roll < on_pct + 8) begin
                add_msg(ACTION_NOTE_ON, base + $urandom_range(5), 0,
                        n == 350 || n == 700);
            end else if (roll < 90) begin
                add_msg(ACTION_NOTE_OFF, base + $urandom_range(5),
                        $urandom_range(127), n == 350 || n == 700);
            end else begin
                add_msg(logic'($urandom_range(1)), $urandom_range(127),
                        $urandom_range(127), n == 350 || n == 700);
            end
        end
        total_msgs = msg_queue.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (msg_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (voice_events.size() != 0) @(posedge i_clk);
        // let any late or spurious beat show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("poly_voice_allocator_top: match");
        end else begin
            $display("poly_voice_allocator_top: mismatch");
        end
        $finish;
    end

endmodule
